### design/fbd_pkg.sv
// ----------------------------------------------------------------------------
// fbd_pkg: shared definitions for the page framebuffer draw engine
// Command codes, default geometry and the walker control/status bundles.
// ----------------------------------------------------------------------------
package fbd_pkg;

	localparam int FBD_SCREEN_WIDTH  = 128;
	localparam int FBD_SCREEN_HEIGHT = 64;

	localparam logic [2:0] CMD_PIXEL  = 3'd0;
	localparam logic [2:0] CMD_FILL   = 3'd1;
	localparam logic [2:0] CMD_INVERT = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_SWAP   = 3'd4;
	localparam logic [2:0] CMD_READ   = 3'd5;

	// sequencer -> walker
	typedef struct packed {
		logic start;    // latch a new rectangle and clip it
		logic advance;  // step to the next byte of the clipped region
	} fbd_walk_ctl_t;

	// walker -> sequencer
	typedef struct packed {
		logic empty;    // clipped region holds no pixel
		logic last;     // current byte is the final one
	} fbd_walk_stat_t;

endpackage

### design/fbd_ram.sv
// ----------------------------------------------------------------------------
// fbd_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbd_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/fbd_walk.sv
// ----------------------------------------------------------------------------
// fbd_walk: rectangle clipper and byte walker
// Clips a rectangle to the screen on start, then steps column by column and
// page by page, giving the byte address and the row mask inside that byte.
// ----------------------------------------------------------------------------
module fbd_walk
	import fbd_pkg::*;
#(
	parameter int SCREEN_WIDTH  = FBD_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = FBD_SCREEN_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fbd_walk_ctl_t         ctl,
	input  logic signed [8:0]     pos_x,
	input  logic signed [8:0]     pos_y,
	input  logic [7:0]            span_w,
	input  logic [7:0]            span_h,
	output logic [$clog2(SCREEN_WIDTH*((SCREEN_HEIGHT+7)/8))-1:0] addr,
	output logic [7:0]            mask,
	output fbd_walk_stat_t        stat
);

	localparam int PAGE_CNT  = (SCREEN_HEIGHT + 7) / 8;
	localparam int BUF_BYTES = SCREEN_WIDTH * PAGE_CNT;
	localparam int AW        = $clog2(BUF_BYTES);
	localparam int COL_W     = $clog2(SCREEN_WIDTH);
	localparam int PAGE_W    = (PAGE_CNT > 1) ? $clog2(PAGE_CNT) : 1;
	localparam logic signed [10:0] SW = 11'(SCREEN_WIDTH);
	localparam logic signed [10:0] SH = 11'(SCREEN_HEIGHT);

	logic signed [10:0] xs, ys, x0, y0, x1, y1, x1c, y1c, xlast, ylast;
	logic               empty_d;

	logic [COL_W-1:0]  col_q, col_first_q, col_last_q;
	logic [PAGE_W-1:0] page_q, page_first_q, page_last_q;
	logic [2:0]        lo_q, hi_q;
	logic [AW:0]       base_q;
	logic              empty_q;

	logic [2:0]  lo, hi;
	logic [AW:0] sum;
	logic        col_end;

	always_comb begin
		xs      = {{2{pos_x[8]}}, pos_x};
		ys      = {{2{pos_y[8]}}, pos_y};
		x1      = xs + $signed({3'b000, span_w});
		y1      = ys + $signed({3'b000, span_h});
		x0      = xs[10] ? '0 : xs;
		y0      = ys[10] ? '0 : ys;
		x1c     = (x1 > SW) ? SW : x1;
		y1c     = (y1 > SH) ? SH : y1;
		xlast   = x1c - 11'sd1;
		ylast   = y1c - 11'sd1;
		empty_d = (x1c <= x0) || (y1c <= y0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b1;
		end else if (ctl.start) begin
			empty_q <= empty_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			col_first_q  <= x0[COL_W-1:0];
			col_q        <= x0[COL_W-1:0];
			col_last_q   <= xlast[COL_W-1:0];
			page_first_q <= y0[PAGE_W+2:3];
			page_q       <= y0[PAGE_W+2:3];
			page_last_q  <= ylast[PAGE_W+2:3];
			lo_q         <= y0[2:0];
			hi_q         <= ylast[2:0];
			base_q       <= (AW+1)'(y0[PAGE_W+2:3]) * (AW+1)'(SCREEN_WIDTH);
		end else if (ctl.advance) begin
			if (col_end) begin
				col_q  <= col_first_q;
				page_q <= page_q + 1'b1;
				base_q <= base_q + (AW+1)'(SCREEN_WIDTH);
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_comb begin
		col_end = (col_q == col_last_q);
		lo      = (page_q == page_first_q) ? lo_q : 3'd0;
		hi      = (page_q == page_last_q) ? hi_q : 3'd7;
		mask    = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
		sum     = base_q + (AW+1)'(col_q);
		addr    = sum[AW-1:0];
		stat.empty = empty_q;
		stat.last  = col_end && (page_q == page_last_q);
	end

endmodule

### design/page_framebuffer_draw_engine_unit.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_unit: double-buffered 1-bit page framebuffer
// Draw commands on the back buffer, swap, and byte reads of the front buffer.
// ----------------------------------------------------------------------------
// Two SCREEN_WIDTH x ceil(SCREEN_HEIGHT/8) byte buffers, one bit per pixel in
// 8-row pages (byte = x + (y/8)*width, bit = y%8). Each accepted request gives
// exactly one response on read_data: the front buffer byte for a read of an
// index below BUF_BYTES, zero for everything else. All drawing goes through a
// single read-modify-write port on the back buffer RAM, so the cost is set by
// how many bytes a request touches: a rectangle reads and writes back each
// touched byte (pages spanned times clipped columns), a pixel is a 1x1
// rectangle, and clear writes every back buffer byte. The unit takes one
// request at a time; in_ready is high only when the sequencer is idle, and a
// finished response sits in the output register while the next request is
// accepted. After reset both buffers are zeroed by a clearing pass over every
// byte, during which in_ready stays low.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_unit
	import fbd_pkg::*;
#(
	parameter int SCREEN_WIDTH  = FBD_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = FBD_SCREEN_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        command,
	input  logic signed [8:0] pos_x,
	input  logic signed [8:0] pos_y,
	input  logic [7:0]        rect_width,
	input  logic [7:0]        rect_height,
	input  logic              pixel_on,
	input  logic [9:0]        byte_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        read_data
);

	localparam int PAGE_CNT  = (SCREEN_HEIGHT + 7) / 8;
	localparam int BUF_BYTES = SCREEN_WIDTH * PAGE_CNT;
	localparam int AW        = $clog2(BUF_BYTES);
	// index compare width: room for byte_index and for BUF_BYTES itself
	localparam int IW        = ((AW > 10) ? AW : 10) + 1;

	// sequencer states
	localparam logic [2:0] ST_INIT  = 3'd0;  // power-up clearing pass
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;  // walker holds clipped bounds
	localparam logic [2:0] ST_RD    = 3'd3;  // read back byte
	localparam logic [2:0] ST_WR    = 3'd4;  // modify and write back
	localparam logic [2:0] ST_CLR   = 3'd5;  // zero back buffer
	localparam logic [2:0] ST_FRD   = 3'd6;  // front byte read in flight
	localparam logic [2:0] ST_DONE  = 3'd7;  // hand response to output reg

	logic [2:0]    state_q;
	logic [2:0]    cmd_q;
	logic          on_q;
	logic          in_range_q;
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] clr_q;
	logic          front_q;
	logic          out_valid_q;
	logic [7:0]    data_q;

	logic           accept;
	logic           resp_load;
	logic [IW-1:0]  idx_ext;
	fbd_walk_ctl_t  walk_ctl;
	fbd_walk_stat_t walk_stat;
	logic [AW-1:0]  walk_addr;
	logic [7:0]     walk_mask;
	logic [7:0]     span_w, span_h;

	logic          back_we;
	logic          we0, we1;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;
	logic [7:0]    rd0, rd1, back_rd, front_rd;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign resp_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign idx_ext   = IW'(byte_index);

	// a single pixel is a 1x1 rectangle; clipping drops it when off screen
	assign span_w = (command == CMD_PIXEL) ? 8'd1 : rect_width;
	assign span_h = (command == CMD_PIXEL) ? 8'd1 : rect_height;

	assign walk_ctl.start   = accept;
	assign walk_ctl.advance = (state_q == ST_WR);

	fbd_walk #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_walk (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (walk_ctl),
		.pos_x (pos_x),
		.pos_y (pos_y),
		.span_w(span_w),
		.span_h(span_h),
		.addr  (walk_addr),
		.mask  (walk_mask),
		.stat  (walk_stat)
	);

	// buffer zero is front while front_q is low
	assign back_rd  = front_q ? rd0 : rd1;
	assign front_rd = front_q ? rd1 : rd0;

	always_comb begin
		back_we = (state_q == ST_WR) || (state_q == ST_CLR);
		we0     = (state_q == ST_INIT) || (back_we && front_q);
		we1     = (state_q == ST_INIT) || (back_we && !front_q);
		waddr   = ((state_q == ST_INIT) || (state_q == ST_CLR)) ? clr_q : walk_addr;
		raddr   = (state_q == ST_RD) ? walk_addr : rd_addr_q;
		wdata   = 8'h00;
		if (state_q == ST_WR) begin
			case (cmd_q)
				CMD_INVERT: wdata = back_rd ^ walk_mask;
				default:    wdata = on_q ? (back_rd | walk_mask) : (back_rd & ~walk_mask);
			endcase
		end
	end

	fbd_ram #(.DATA_W(8), .DEPTH(BUF_BYTES)) u_buf0 (
		.clk  (clk),
		.we   (we0),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd0)
	);

	fbd_ram #(.DATA_W(8), .DEPTH(BUF_BYTES)) u_buf1 (
		.clk  (clk),
		.we   (we1),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd1)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q   <= '0;
			front_q <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (clr_q == AW'(BUF_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (command)
							CMD_PIXEL, CMD_FILL, CMD_INVERT: state_q <= ST_SETUP;
							CMD_CLEAR: begin
								state_q <= ST_CLR;
								clr_q   <= '0;
							end
							CMD_READ: state_q <= ST_FRD;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_SETUP: state_q <= walk_stat.empty ? ST_DONE : ST_RD;
				ST_RD:    state_q <= ST_WR;
				ST_WR:    state_q <= walk_stat.last ? ST_DONE : ST_RD;
				ST_CLR: begin
					if (clr_q == AW'(BUF_BYTES - 1)) begin
						state_q <= ST_DONE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_FRD: state_q <= ST_DONE;
				ST_DONE: begin
					if (resp_load) begin
						state_q <= ST_IDLE;
						if (cmd_q == CMD_SWAP) begin
							front_q <= !front_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request fields held for the duration of the command
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= command;
			on_q       <= pixel_on;
			in_range_q <= (idx_ext < IW'(BUF_BYTES));
			rd_addr_q  <= idx_ext[AW-1:0];
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			data_q <= ((cmd_q == CMD_READ) && in_range_q) ? front_rd : 8'h00;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = data_q;

	// front/back only exchange when a swap request completes
	a_swap_only: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(front_q) |-> $past(state_q == ST_DONE && cmd_q == CMD_SWAP))
		else $error("front buffer changed without a swap");

	// every write-back is preceded by its read
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR |-> $past(state_q) == ST_RD)
		else $error("write-back without a preceding read");

	// the walker never drives a read for an empty clipped region
	a_no_empty_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> !walk_stat.empty)
		else $error("walk of an empty rectangle");

endmodule

### verif/page_framebuffer_draw_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_unit_tb: self-checking bench for the draw engine
// Drives draw, swap and read requests over valid/ready, keeps its own copy of
// both page buffers and checks every read_data response against it in order.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_unit_tb
	import fbd_pkg::*;
();

	localparam int SCR_W     = FBD_SCREEN_WIDTH;
	localparam int SCR_H     = FBD_SCREEN_HEIGHT;
	localparam int PAGES     = (SCR_H + 7) / 8;
	localparam int BUF_BYTES = SCR_W * PAGES;

	// codes the unit must treat as no-ops
	localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

	// full-screen invert reads and writes back all BUF_BYTES bytes; the limit
	// covers that walk plus the clearing pass after reset and the long output hold, several times over
	localparam int STALL_LIMIT      = 10000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES      = 32;

	typedef enum logic [1:0] {
		PAINT_CLEAR,
		PAINT_SET,
		PAINT_TOGGLE
	} paint_mode_t;

	typedef struct {
		logic [2:0]        cmd;
		logic signed [8:0] x;
		logic signed [8:0] y;
		logic [7:0]        w;
		logic [7:0]        h;
		logic              on;
		logic [9:0]        idx;
	} draw_req_t;

	typedef struct {
		logic [2:0] cmd;
		logic [7:0] data;
	} read_expect_t;

	// DUT signals; every input starts at a known value
	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [2:0]        command     = '0;
	logic signed [8:0] pos_x       = '0;
	logic signed [8:0] pos_y       = '0;
	logic [7:0]        rect_width  = '0;
	logic [7:0]        rect_height = '0;
	logic              pixel_on    = 1'b0;
	logic [9:0]        byte_index  = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [7:0]        read_data;

	// shadow framebuffer: two page buffers and which one is on display
	logic [7:0]   page_mem [2][BUF_BYTES];
	logic         front_sel;

	draw_req_t    pending_reqs[$];
	read_expect_t expected_bytes[$];

	int reqs_queued    = 0;   // pushed by the stimulus
	int reqs_offered   = 0;   // raised on in_valid by the driver
	int reqs_taken     = 0;   // accepted at a rising edge
	int results_taken  = 0;
	int results_acked  = 0;
	int holds_asked    = 0;
	int holds_begun    = 0;
	int gap_left       = 0;
	int stall_left     = 0;
	int hold_left      = 0;
	int idle_cycles    = 0;
	int fail_count     = 0;
	int cmd_count [8];
	int hot_x          = 0;   // where recent drawing happened, steers reads
	int hot_y          = 0;
	bit no_idle        = 1'b0;

	page_framebuffer_draw_engine_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.pixel_on    (pixel_on),
		.byte_index  (byte_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_data   (read_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow framebuffer
	// ------------------------------------------------------------------

	// one pixel of the back buffer; caller has already clipped it
	function automatic void paint(int px, int py, paint_mode_t mode);
		int         addr;
		logic [7:0] mask;
		addr = px + (py / 8) * SCR_W;
		mask = 8'(1 << (py % 8));
		case (mode)
			PAINT_CLEAR: page_mem[!front_sel][addr] &= ~mask;
			PAINT_SET:   page_mem[!front_sel][addr] |= mask;
			default:     page_mem[!front_sel][addr] ^= mask;
		endcase
	endfunction

	// applies one request to the shadow buffers, returns the byte it answers
	function automatic logic [7:0] frame_step(draw_req_t r);
		int          x, y, x0, y0, x1, y1, px, py, i;
		paint_mode_t mode;
		logic [7:0]  rd;
		rd = '0;
		x  = int'(r.x);
		y  = int'(r.y);
		case (r.cmd)
			CMD_PIXEL: begin
				if (x >= 0 && x < SCR_W && y >= 0 && y < SCR_H)
					paint(x, y, r.on ? PAINT_SET : PAINT_CLEAR);
			end
			CMD_FILL, CMD_INVERT: begin
				// clip on all four sides; empty when width or height is zero
				mode = (r.cmd == CMD_INVERT) ? PAINT_TOGGLE :
					(r.on ? PAINT_SET : PAINT_CLEAR);
				x0 = (x < 0) ? 0 : x;
				y0 = (y < 0) ? 0 : y;
				x1 = x + int'(r.w);
				y1 = y + int'(r.h);
				if (x1 > SCR_W) x1 = SCR_W;
				if (y1 > SCR_H) y1 = SCR_H;
				for (py = y0; py < y1; py++)
					for (px = x0; px < x1; px++)
						paint(px, py, mode);
			end
			CMD_CLEAR: begin
				for (i = 0; i < BUF_BYTES; i++)
					page_mem[!front_sel][i] = '0;
			end
			CMD_SWAP: front_sel = !front_sel;
			CMD_READ: begin
				if (int'(r.idx) < BUF_BYTES)
					rd = page_mem[front_sel][r.idx];
			end
			default: ;
		endcase
		return rd;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic void queue_request(logic [2:0] cmd, int x, int y, int w, int h,
		bit on, int idx);
		draw_req_t r;
		r.cmd = cmd;
		r.x   = x[8:0];
		r.y   = y[8:0];
		r.w   = w[7:0];
		r.h   = h[7:0];
		r.on  = on;
		r.idx = idx[9:0];
		pending_reqs.push_back(r);
		reqs_queued++;
	endfunction

	// a draw near the visible area, occasionally a large rectangle or a clear
	function automatic void queue_draw();
		int         pick, x, y, w, h;
		logic [2:0] cmd;
		pick = $urandom_range(0, 99);
		cmd  = (pick < 40) ? CMD_PIXEL : (pick < 68) ? CMD_FILL :
			(pick < 97) ? CMD_INVERT : CMD_CLEAR;
		x = $urandom_range(0, SCR_W + 32) - 16;
		y = $urandom_range(0, SCR_H + 16) - 8;
		if ($urandom_range(0, 9) == 0) begin
			w = $urandom_range(0, 255);
			h = $urandom_range(0, 255);
		end else begin
			w = $urandom_range(0, 24);
			h = $urandom_range(0, 24);
		end
		hot_x = (x < 0) ? 0 : (x >= SCR_W) ? SCR_W - 1 : x;
		hot_y = (y < 0) ? 0 : (y >= SCR_H) ? SCR_H - 1 : y;
		queue_request(cmd, x, y, w, h, 1'($urandom_range(0, 1)), $urandom_range(0, 1023));
	endfunction

	// a read, mostly of bytes around the last drawing
	function automatic void queue_read();
		int idx;
		if ($urandom_range(0, 9) < 7)
			idx = (hot_x + $urandom_range(0, 15)) % SCR_W +
				((hot_y / 8 + $urandom_range(0, 1)) % PAGES) * SCR_W;
		else
			idx = $urandom_range(0, 1023);
		queue_request(CMD_READ, $urandom_range(0, 511), $urandom_range(0, 511),
			$urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom_range(0, 1)), idx);
	endfunction

	// anything at all, every field over its full range
	function automatic void queue_noise();
		queue_request(3'($urandom_range(0, 7)), $urandom_range(0, 511) - 256,
			$urandom_range(0, 511) - 256, $urandom_range(0, 255), $urandom_range(0, 255),
			1'($urandom_range(0, 1)), $urandom_range(0, 1023));
	endfunction

	// draw on the back buffer, bring it to the front, read it back
	function automatic void queue_scene();
		int n, k;
		n = $urandom_range(1, 5);
		for (k = 0; k < n; k++) queue_draw();
		queue_request(CMD_SWAP, 0, 0, 0, 0, 0, 0);
		n = $urandom_range(1, 4);
		for (k = 0; k < n; k++) queue_read();
		if ($urandom_range(0, 4) == 0) queue_noise();
	endfunction

	task automatic wait_drained();
		while (!(reqs_taken == reqs_queued && expected_bytes.size() == 0))
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Request driver: changes inputs on the falling edge. An item stays on
	// the bus until the monitor has seen it accepted; the next one may then
	// be held back by a random idle gap (none in no-idle stretches).
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		draw_req_t nxt;
		if (arst_n && !(in_valid && reqs_taken != reqs_offered)) begin
			if (in_valid)
				gap_left = no_idle ? 0 : $urandom_range(0, 3);
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				nxt = pending_reqs.pop_front();
				command     <= nxt.cmd;
				pos_x       <= nxt.x;
				pos_y       <= nxt.y;
				rect_width  <= nxt.w;
				rect_height <= nxt.h;
				pixel_on    <= nxt.on;
				byte_index  <= nxt.idx;
				in_valid    <= 1'b1;
				reqs_offered++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Response side ready: a random stall after each response, and
	// a long hold on demand so the unit backs up and drops in_ready.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (holds_begun != holds_asked) begin
			holds_begun = holds_asked;
			hold_left   = LONG_HOLD_CYCLES;
		end
		if (results_taken != results_acked) begin
			results_acked = results_taken;
			stall_left    = no_idle ? 0 : $urandom_range(0, 3);
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor on the rising edge. Responses are checked before the request
	// taken on the same edge is predicted: the sequencer and the output register
	// lie between accept and response, so none can belong to a request taken at that edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		read_expect_t want;
		draw_req_t    got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_taken++;
				if (expected_bytes.size() == 0) begin
					$display("%0t: stray response, expected none, actual %02h",
						$time, read_data);
					fail_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (read_data !== want.data) begin
						$display("%0t: read_data mismatch (command %0d), expected %02h, actual %02h",
							$time, want.cmd, want.data, read_data);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				got.cmd = command;
				got.x   = pos_x;
				got.y   = pos_y;
				got.w   = rect_width;
				got.h   = rect_height;
				got.on  = pixel_on;
				got.idx = byte_index;
				want.cmd  = command;
				want.data = frame_step(got);
				expected_bytes.push_back(want);
				cmd_count[command]++;
				reqs_taken++;
			end
			// watchdog: only counts while there is still work outstanding
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else if (reqs_taken != reqs_queued || expected_bytes.size() != 0)
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d requests, %0d responses left",
					$time, idle_cycles, reqs_queued - reqs_taken, expected_bytes.size());
				$display("page_framebuffer_draw_engine_unit verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		foreach (page_mem[b, i])
			page_mem[b][i] = '0;
		front_sel = 1'b0;
		foreach (cmd_count[c])
			cmd_count[c] = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset contents, screen edges, clipping, empty rectangles
		queue_request(CMD_READ, 0, 0, 0, 0, 0, 0);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, BUF_BYTES - 1);
		queue_request(CMD_PIXEL, 0, 0, 0, 0, 1, 0);
		queue_request(CMD_PIXEL, SCR_W - 1, SCR_H - 1, 0, 0, 1, 0);
		queue_request(CMD_PIXEL, SCR_W, 3, 0, 0, 1, 0);         // right of screen
		queue_request(CMD_PIXEL, -1, 5, 0, 0, 1, 0);            // left of screen
		queue_request(CMD_PIXEL, 3, SCR_H, 0, 0, 1, 0);         // below screen
		queue_request(CMD_PIXEL, 255, -256, 0, 0, 1, 0);
		queue_request(CMD_FILL, -5, -3, 10, 12, 1, 0);          // clipped top-left
		queue_request(CMD_FILL, 10, 10, 0, 5, 1, 0);            // zero width
		queue_request(CMD_FILL, 10, 10, 5, 0, 1, 0);            // zero height
		queue_request(CMD_FILL, 2, 2, 1, 1, 0, 0);
		queue_request(CMD_INVERT, -256, -256, 255, 255, 0, 0);  // never reaches screen
		queue_request(CMD_INVERT, SCR_W - 8, SCR_H - 4, 255, 255, 0, 0);
		queue_request(CMD_SWAP, 0, 0, 0, 0, 0, 0);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, 0);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, 1);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, SCR_W);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, BUF_BYTES - 8);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, BUF_BYTES - 1);
		queue_request(CMD_PIXEL, 0, 0, 0, 0, 0, 0);
		queue_request(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		queue_request(CMD_INVERT, 0, 0, 255, 255, 0, 0);        // whole screen
		queue_request(CMD_SWAP, 0, 0, 0, 0, 0, 0);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, 517);
		queue_request(CMD_UNUSED_6, 5, 5, 9, 9, 1, 5);
		queue_request(CMD_UNUSED_7, -256, 255, 255, 255, 1, 1023);

		// random scenes with idling on both sides
		while (reqs_queued < 280)
			queue_scene();
		wait_drained();

		// back-to-back stretch, no idling anywhere
		no_idle = 1'b1;
		while (reqs_queued < 380)
			queue_scene();
		wait_drained();
		no_idle = 1'b0;

		// long response hold while requests keep coming
		holds_asked++;
		while (reqs_queued < 420)
			queue_scene();
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d pixel, %0d fill, %0d invert, %0d clear, %0d swap,",
			reqs_taken, cmd_count[CMD_PIXEL], cmd_count[CMD_FILL], cmd_count[CMD_INVERT],
			cmd_count[CMD_CLEAR], cmd_count[CMD_SWAP]);
		$display("  %0d reads, %0d unused codes; random gaps, a no-idle stretch, one long hold",
			cmd_count[CMD_READ], cmd_count[CMD_UNUSED_6] + cmd_count[CMD_UNUSED_7]);
		if (fail_count == 0 && expected_bytes.size() == 0)
			$display("page_framebuffer_draw_engine_unit verification clean");
		else
			$display("page_framebuffer_draw_engine_unit verification failed");
		$finish;
	end

endmodule

### page_framebuffer_draw_engine_unit.f
design/fbd_pkg.sv
design/fbd_ram.sv
design/fbd_walk.sv
design/page_framebuffer_draw_engine_unit.sv
verif/page_framebuffer_draw_engine_unit_tb.sv
